// ===== src/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

  // field and register widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BYTE_IDX_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned USER_W     = 2;

  // defaults for the top level parameters
  localparam int unsigned DEF_MAX_PATTERN     = 8;
  localparam int unsigned DEF_MAX_REPLACEMENT = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd3;

  // configuration as seen by the scanner
  typedef struct packed {
    logic [LEN_W-1:0]  pattern_length;
    logic [WORD_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]  replacement_length;
    logic [WORD_W-1:0] replacement_bytes;
  } sfr_cfg_t;

  // one result item held in a chain cell
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              status;
    logic              out_last;
  } sfr_entry_t;

  // chain control shared by all cells
  typedef struct packed {
    logic load;
    logic shift;
  } sfr_ctrl_t;

  // byte idx of a 64-bit word, byte 0 in the low bits
  function automatic logic [BYTE_W-1:0] pick_byte(input logic [WORD_W-1:0] word,
                                                  input logic [BYTE_IDX_W-1:0] idx);
    pick_byte = word[BYTE_W*idx +: BYTE_W];
  endfunction

endpackage

// ===== src/sfr_cell.sv =====
`timescale 1ns / 1ps

module sfr_cell
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sfr_ctrl_t  ctrl_i,
  input  logic       load_valid_i,
  input  sfr_entry_t load_entry_i,
  input  logic       next_valid_i,
  input  sfr_entry_t next_entry_i,
  output logic       valid_o,
  output sfr_entry_t entry_o
);

  logic       valid_d, valid_q;
  sfr_entry_t entry_d, entry_q;

  // parallel load from the scanner, otherwise on a shift take the neighbor's item, else hold
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.load) begin
      valid_d = load_valid_i;
      entry_d = load_entry_i;
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ===== src/sfr_scan.sv =====
`timescale 1ns / 1ps

module sfr_scan
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int unsigned MAX_REPLACEMENT = DEF_MAX_REPLACEMENT,
  parameter int unsigned CHAIN_DEPTH     = DEF_MAX_PATTERN
) (
  input  sfr_cfg_t                     cfg_i,
  input  logic [LEN_W-1:0]             prefix_i,
  input  logic [BYTE_W-1:0]            in_byte_i,
  input  logic                         in_last_i,
  output logic [CHAIN_DEPTH-1:0]       load_valid_o,
  output sfr_entry_t [CHAIN_DEPTH-1:0] load_entry_o,
  output logic [LEN_W-1:0]             prefix_o
);

  logic [LEN_W-1:0]  plen, rlen, k, len, tail, cnt;
  logic [BYTE_W-1:0] pk;
  logic              hit, full, use_repl, marker, marker_status;

  // clamp lengths, limit the held prefix to pattern length minus one
  always_comb begin
    plen = (cfg_i.pattern_length > LEN_W'(MAX_PATTERN)) ?
           LEN_W'(MAX_PATTERN) : cfg_i.pattern_length;
    rlen = (cfg_i.replacement_length > LEN_W'(MAX_REPLACEMENT)) ?
           LEN_W'(MAX_REPLACEMENT) : cfg_i.replacement_length;
    k    = prefix_i;
    if (plen != '0 && prefix_i >= plen) begin
      k = plen - LEN_W'(1);
    end
    len  = k + LEN_W'(1);
    pk   = pick_byte(cfg_i.pattern_bytes, k[BYTE_IDX_W-1:0]);
    hit  = (in_byte_i == pk);
    full = hit && (len == plen);
  end

  // longest tail of held prefix plus new byte that is again a pattern prefix
  always_comb begin
    logic ok;
    logic [BYTE_IDX_W-1:0] idx;
    tail = '0;
    for (int mm = 1; mm < MAX_PATTERN; mm++) begin
      ok = (LEN_W'(mm) <= k) &&
           (in_byte_i == pick_byte(cfg_i.pattern_bytes, BYTE_IDX_W'(mm - 1)));
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        idx = BYTE_IDX_W'(int'(k) - mm + 1 + i);
        if (i < mm - 1) begin
          ok = ok && (pick_byte(cfg_i.pattern_bytes, idx) ==
                      pick_byte(cfg_i.pattern_bytes, BYTE_IDX_W'(i)));
        end
      end
      if (ok) begin
        tail = LEN_W'(mm);
      end
    end
  end

  // how many items, from which source, and the new prefix length
  always_comb begin
    cnt           = '0;
    use_repl      = 1'b0;
    marker        = 1'b0;
    marker_status = 1'b0;
    prefix_o      = '0;
    if (plen == '0) begin
      marker        = in_last_i;
      marker_status = 1'b1;
    end else if (full) begin
      use_repl = 1'b1;
      cnt      = rlen;
      marker   = in_last_i && (rlen == '0);
    end else if (hit) begin
      cnt      = in_last_i ? len : '0;
      prefix_o = in_last_i ? '0 : len;
    end else begin
      cnt      = in_last_i ? len : (len - tail);
      prefix_o = in_last_i ? '0 : tail;
    end
  end

  // fill the chain image
  always_comb begin
    logic [BYTE_W-1:0] held;
    for (int j = 0; j < CHAIN_DEPTH; j++) begin
      held = (LEN_W'(j) < k) ? pick_byte(cfg_i.pattern_bytes, BYTE_IDX_W'(j)) : in_byte_i;
      load_valid_o[j]            = LEN_W'(j) < cnt;
      load_entry_o[j].out_byte   = use_repl ?
                                   pick_byte(cfg_i.replacement_bytes, BYTE_IDX_W'(j)) : held;
      load_entry_o[j].byte_valid = 1'b1;
      load_entry_o[j].status     = 1'b0;
      load_entry_o[j].out_last   = in_last_i && (LEN_W'(j + 1) == cnt);
    end
    // end marker when the final item gives no text
    if (marker) begin
      load_valid_o[0]            = 1'b1;
      load_entry_o[0].out_byte   = '0;
      load_entry_o[0].byte_valid = 1'b0;
      load_entry_o[0].status     = marker_status;
      load_entry_o[0].out_last   = 1'b1;
    end
  end

endmodule

// ===== src/stream_find_replace.sv =====
`timescale 1ns / 1ps

// Streaming find and replace over a byte stream.
// Input channel s_axis: one text byte per item in tdata, tlast on the final
// byte of a stream. Output channel m_axis: one text byte per item in tdata,
// tuser[0] byte_valid (0 for an end marker), tuser[1] status (1 when the
// pattern is empty), tlast on the final item of the stream.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i only
// while the stream is idle; the user must keep to this, the block does not
// enforce it: 0 pattern length, 1 pattern bytes, 2 replacement length,
// 3 replacement bytes (byte 0 in the low bits). Each accepted byte is
// scanned in its cycle and its results are loaded in parallel into a chain
// of output cells; while m_axis accepts, the chain shifts one item per cycle
// toward the output register of cell 0. With m_axis accepting, plain text
// flows at one byte per cycle; a byte that releases n results (at most
// max(MAX_PATTERN, MAX_REPLACEMENT)) holds off the next byte while the chain
// drains. s_axis_tready_o is high while at most the head cell is full and
// leaving. A stalled m_axis holds the head item and holds s_axis_tready_o
// low until that item leaves. Reset clears the chain, the held prefix
// length and all configuration registers.

module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int unsigned MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [BYTE_W-1:0]    s_axis_tdata_i,  // in_byte
  input  logic                 s_axis_tlast_i,  // in_last
  // output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [BYTE_W-1:0]    m_axis_tdata_o,  // out_byte
  output logic [USER_W-1:0]    m_axis_tuser_o,  // byte_valid, status
  output logic                 m_axis_tlast_o   // out_last
);

  localparam int unsigned CHAIN_DEPTH =
    (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

  sfr_cfg_t                     cfg_d, cfg_q;
  logic [LEN_W-1:0]             prefix_d, prefix_q;
  logic [CHAIN_DEPTH-1:0]       load_valid, cell_valid;
  sfr_entry_t [CHAIN_DEPTH-1:0] load_entry, cell_entry;
  logic [CHAIN_DEPTH:0]         nxt_valid;
  sfr_entry_t [CHAIN_DEPTH:0]   nxt_entry;
  sfr_ctrl_t                    ctrl;
  logic                         in_fire, out_fire;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATTERN_LENGTH:     cfg_d.pattern_length     = cfg_data_i[LEN_W-1:0];
        REG_PATTERN_BYTES:      cfg_d.pattern_bytes      = cfg_data_i;
        REG_REPLACEMENT_LENGTH: cfg_d.replacement_length = cfg_data_i[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  cfg_d.replacement_bytes  = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // handshakes: accept while the chain holds at most a leaving head item
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = !nxt_valid[1] && (!nxt_valid[0] || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign ctrl.load       = in_fire;
  assign ctrl.shift      = out_fire;

  // scanner for the accepted byte
  sfr_scan #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .CHAIN_DEPTH     (CHAIN_DEPTH)
  ) u_scan (
    .cfg_i        (cfg_q),
    .prefix_i     (prefix_q),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .load_valid_o (load_valid),
    .load_entry_o (load_entry),
    .prefix_o     (prefix_d)
  );

  // held prefix length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
    end else if (in_fire) begin
      prefix_q <= prefix_d;
    end
  end

  // output chain, cell 0 drives the port
  assign nxt_valid[CHAIN_DEPTH] = 1'b0;
  assign nxt_entry[CHAIN_DEPTH] = '0;

  for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_cell
    sfr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_valid_i (load_valid[g]),
      .load_entry_i (load_entry[g]),
      .next_valid_i (nxt_valid[g+1]),
      .next_entry_i (nxt_entry[g+1]),
      .valid_o      (cell_valid[g]),
      .entry_o      (cell_entry[g])
    );
    assign nxt_valid[g] = cell_valid[g];
    assign nxt_entry[g] = cell_entry[g];
  end

  assign m_axis_tvalid_o = nxt_valid[0];
  assign m_axis_tdata_o  = nxt_entry[0].out_byte;
  assign m_axis_tuser_o  = {nxt_entry[0].status, nxt_entry[0].byte_valid};
  assign m_axis_tlast_o  = nxt_entry[0].out_last;

  // occupied cells always form a run from the head
  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("chain holds a gap");

  // a partial match is always shorter than the longest pattern
  a_prefix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q < LEN_W'(MAX_PATTERN))
    else $error("held prefix too long");

  // the final byte of a stream leaves nothing held
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tlast_i |=> prefix_q == '0)
    else $error("prefix kept after last byte");

  // an end marker is always the final item
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("end marker without tlast");

endmodule
